// ===== design/ebqt_pkg.sv =====
// Package for the escaped brace/quote tokenizer.
// Holds the transaction types, register indexes, status codes and reset values.
// No dependencies.
`default_nettype none

package ebqt_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_done;
        logic [1:0] token_status;
        logic       last_flag;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  res0;
        out_item_t  res1;
    } step_res_t;

    localparam logic [1:0] REG_OPEN_GROUP  = 2'd0;
    localparam logic [1:0] REG_CLOSE_GROUP = 2'd1;
    localparam logic [1:0] REG_QUOTE       = 2'd2;
    localparam logic [1:0] REG_ESCAPE      = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNTERM   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [7:0] OPEN_GROUP_RESET  = 8'd123;
    localparam logic [7:0] CLOSE_GROUP_RESET = 8'd125;
    localparam logic [7:0] QUOTE_RESET       = 8'd34;
    localparam logic [7:0] ESCAPE_RESET      = 8'd92;

endpackage

`default_nettype wire

// ===== design/ebqt_core.sv =====
// Next-state and result logic of the tokenizer for one input byte.
// Purely combinational; depends on ebqt_pkg.
`default_nettype none

module ebqt_core
    import ebqt_pkg::*;
#(
    parameter int MAX_DEPTH = 16,
    localparam int DW = $clog2(MAX_DEPTH + 1)
)(
    input  wire in_item_t   item,
    input  wire [2:0]       mode,
    input  wire             is_quote,
    input  wire [DW-1:0]    depth,
    input  wire             overflow,
    input  wire [7:0]       open_char,
    input  wire [7:0]       close_char,
    input  wire [7:0]       quote_char,
    input  wire [7:0]       escape_char,
    output logic [2:0]      mode_next,
    output logic            is_quote_next,
    output logic [DW-1:0]   depth_next,
    output logic            overflow_next,
    output step_res_t       step
);

    localparam logic [2:0] MODE_SKIP       = 3'd0;
    localparam logic [2:0] MODE_LEAD_ESC   = 3'd1;
    localparam logic [2:0] MODE_LEAD_AFTER = 3'd2;
    localparam logic [2:0] MODE_WORD       = 3'd3;
    localparam logic [2:0] MODE_WORD_ESC   = 3'd4;
    localparam logic [2:0] MODE_GROUP      = 3'd5;
    localparam logic [2:0] MODE_GROUP_ESC  = 3'd6;

    localparam logic [DW-1:0] DEPTH_ONE = DW'(1);
    localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

    function automatic out_item_t mk_res(input logic [7:0] b, input logic valid,
                                         input logic done, input logic [1:0] status);
        out_item_t r;
        r.out_byte     = valid ? b : 8'd0;
        r.byte_valid   = valid;
        r.token_done   = done;
        r.token_status = done ? status : STATUS_OK;
        r.last_flag    = 1'b0;
        return r;
    endfunction

    logic [7:0] b;
    logic       eos;
    logic       ws;
    logic [7:0] oc;
    logic [7:0] cc;
    logic [1:0] grp_ok;
    logic [1:0] grp_unterm;

    always_comb
    begin
        b          = item.in_byte;
        eos        = item.end_of_stream;
        ws         = b inside {8'd32, [8'd9:8'd13]};
        oc         = is_quote ? quote_char : open_char;
        cc         = is_quote ? quote_char : close_char;
        grp_ok     = overflow ? STATUS_OVERFLOW : STATUS_OK;
        grp_unterm = overflow ? STATUS_OVERFLOW : STATUS_UNTERM;

        mode_next     = mode;
        is_quote_next = is_quote;
        depth_next    = depth;
        overflow_next = overflow;
        step.count    = 2'd0;
        step.res0     = '0;
        step.res1     = '0;

        case (mode)
            MODE_SKIP:
            begin
                if (eos)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(8'd0, 1'b0, 1'b1, STATUS_EMPTY);
                    mode_next  = MODE_SKIP;
                end
                else if (ws)
                begin
                    mode_next = MODE_SKIP;
                end
                else if (b == escape_char)
                begin
                    mode_next = MODE_LEAD_ESC;
                end
                else if (b == quote_char || b == open_char)
                begin
                    mode_next     = MODE_GROUP;
                    is_quote_next = (b == quote_char);
                    depth_next    = DEPTH_ONE;
                    overflow_next = 1'b0;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_WORD;
                end
            end
            MODE_LEAD_ESC:
            begin
                step.count = 2'd1;
                if (eos)
                begin
                    step.res0 = mk_res(escape_char, 1'b1, 1'b1, STATUS_OK);
                    mode_next = MODE_SKIP;
                end
                else
                begin
                    step.res0 = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next = MODE_LEAD_AFTER;
                end
            end
            MODE_LEAD_AFTER:
            begin
                if (eos || ws)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                    mode_next  = MODE_SKIP;
                end
                else if (b == quote_char || b == open_char)
                begin
                    mode_next     = MODE_GROUP;
                    is_quote_next = (b == quote_char);
                    depth_next    = DEPTH_ONE;
                    overflow_next = 1'b0;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_WORD;
                end
            end
            MODE_WORD:
            begin
                if (eos || ws)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(8'd0, 1'b0, 1'b1, STATUS_OK);
                    mode_next  = MODE_SKIP;
                end
                else if (b == escape_char)
                begin
                    mode_next = MODE_WORD_ESC;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                end
            end
            MODE_WORD_ESC:
            begin
                if (eos)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(escape_char, 1'b1, 1'b1, STATUS_OK);
                    mode_next  = MODE_SKIP;
                end
                else if (ws)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_WORD;
                end
                else
                begin
                    step.count = 2'd2;
                    step.res0  = mk_res(escape_char, 1'b1, 1'b0, STATUS_OK);
                    step.res1  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_WORD;
                end
            end
            MODE_GROUP:
            begin
                if (eos)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(8'd0, 1'b0, 1'b1, grp_unterm);
                    mode_next  = MODE_SKIP;
                end
                else if (b == cc)
                begin
                    step.count = 2'd1;
                    if (depth <= DEPTH_ONE)
                    begin
                        step.res0 = mk_res(8'd0, 1'b0, 1'b1, grp_ok);
                        mode_next = MODE_SKIP;
                    end
                    else
                    begin
                        step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                        depth_next = depth - DEPTH_ONE;
                    end
                end
                else if (b == oc)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    if (depth >= DEPTH_MAX)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth + DEPTH_ONE;
                    end
                end
                else if (b == escape_char)
                begin
                    mode_next = MODE_GROUP_ESC;
                end
                else
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                end
            end
            MODE_GROUP_ESC:
            begin
                if (eos)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(escape_char, 1'b1, 1'b1, grp_unterm);
                    mode_next  = MODE_SKIP;
                end
                else if (b == oc || b == cc)
                begin
                    step.count = 2'd1;
                    step.res0  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_GROUP;
                end
                else
                begin
                    step.count = 2'd2;
                    step.res0  = mk_res(escape_char, 1'b1, 1'b0, STATUS_OK);
                    step.res1  = mk_res(b, 1'b1, 1'b0, STATUS_OK);
                    mode_next  = MODE_GROUP;
                end
            end
            default:
            begin
                mode_next = MODE_SKIP;
            end
        endcase

        if (mode_next == MODE_SKIP)
        begin
            is_quote_next = 1'b0;
            depth_next    = '0;
            overflow_next = 1'b0;
        end

        if (step.count == 2'd1)
        begin
            step.res0.last_flag = 1'b1;
        end
        else if (step.count == 2'd2)
        begin
            step.res1.last_flag = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/ebqt_outq.sv =====
// Four-entry result queue that takes up to two results per cycle and gives one.
// Depends on ebqt_pkg.
`default_nettype none

module ebqt_outq
    import ebqt_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  wire step_res_t  step,
    output logic            space,
    output logic            out_valid,
    input  wire             out_ready,
    output out_item_t       out_data
);

    out_item_t  mem_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] push_cnt;
    logic       pop;

    always_comb
    begin
        out_valid   = (count_reg != 3'd0);
        space       = (count_reg < 3'd3);
        out_data    = mem_reg[rd_ptr_reg];
        push_cnt    = push ? step.count : 2'd0;
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= step.res0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= step.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/escaped_brace_quote_tokenizer.sv =====
// Results of an accepted item are written into the result queue and offered from its registers.
// Throughput: one item per cycle, with room in the queue, while items give one result at most;
// the single output port of the result queue sets the rate, so two-result items slow the flow.
// Reset: asynchronous, active low; registers return to their defaults, the parser to
// skipping whitespace and the result queue to empty.
// Top level of the tokenizer; depends on ebqt_pkg, ebqt_core and ebqt_outq.
`default_nettype none

module escaped_brace_quote_tokenizer
    import ebqt_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cfg_write,
    input  wire [1:0]       cfg_index,
    input  wire [7:0]       cfg_data,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire             out_ready,
    output out_item_t       out_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic [7:0]    open_reg;
    logic [7:0]    close_reg;
    logic [7:0]    quote_reg;
    logic [7:0]    escape_reg;
    logic [2:0]    mode_reg;
    logic [2:0]    mode_next;
    logic          is_quote_reg;
    logic          is_quote_next;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic          overflow_reg;
    logic          overflow_next;
    step_res_t     step;
    logic          accept;

    assign accept = in_valid && in_ready;

    ebqt_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .item          (in_data),
        .mode          (mode_reg),
        .is_quote      (is_quote_reg),
        .depth         (depth_reg),
        .overflow      (overflow_reg),
        .open_char     (open_reg),
        .close_char    (close_reg),
        .quote_char    (quote_reg),
        .escape_char   (escape_reg),
        .mode_next     (mode_next),
        .is_quote_next (is_quote_next),
        .depth_next    (depth_next),
        .overflow_next (overflow_next),
        .step          (step)
    );

    ebqt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .step      (step),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg   <= OPEN_GROUP_RESET;
            close_reg  <= CLOSE_GROUP_RESET;
            quote_reg  <= QUOTE_RESET;
            escape_reg <= ESCAPE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OPEN_GROUP:  open_reg   <= cfg_data;
                REG_CLOSE_GROUP: close_reg  <= cfg_data;
                REG_QUOTE:       quote_reg  <= cfg_data;
                REG_ESCAPE:      escape_reg <= cfg_data;
                default:         open_reg   <= open_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            is_quote_reg <= 1'b0;
            depth_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            is_quote_reg <= is_quote_next;
            depth_reg    <= depth_next;
            overflow_reg <= overflow_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/ebqt_checker.sv =====
// Port-level checks for the tokenizer and the bind that attaches them.
// Depends on ebqt_pkg and escaped_brace_quote_tokenizer.
`default_nettype none

module ebqt_assert
    import ebqt_pkg::*;
(
    input wire             clk,
    input wire             rst_n,
    input wire             out_valid,
    input wire             out_ready,
    input wire out_item_t  out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output transaction changed while stalled.");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.byte_valid |-> out_data.out_byte == 8'd0)
        else $error("Output byte is nonzero without a body byte.");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.token_done |-> out_data.token_status == STATUS_OK)
        else $error("Status is set on a transaction that does not end a token.");

    a_empty_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.token_done && out_data.token_status == STATUS_EMPTY
        |-> !out_data.byte_valid && out_data.last_flag)
        else $error("Empty token carries a byte or is not the last result.");

endmodule

bind escaped_brace_quote_tokenizer ebqt_assert u_ebqt_assert (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/ebqt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the escaped brace/quote tokenizer: watches the register port and both channels,
// predicts every result transaction and compares it with what the block delivers.
// Depends on ebqt_pkg.

module ebqt_checker
    import ebqt_pkg::*;
#(
    parameter int MAX_DEPTH = 16
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        mismatches,
    output int        outstanding
);

    typedef enum logic [2:0] {
        SKIP_WS,
        LEAD_ESC,
        LEAD_AFTER,
        IN_WORD,
        WORD_ESC,
        IN_GROUP,
        GROUP_ESC
    } parse_mode_t;

    logic [7:0]  open_chr;
    logic [7:0]  close_chr;
    logic [7:0]  quote_chr;
    logic [7:0]  escape_chr;
    parse_mode_t mode;
    logic        quoted;
    int          depth;
    logic        overflow;

    out_item_t   token_results[$];
    out_item_t   step_res[2];
    int          step_cnt;

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [1:0] group_status(input logic [1:0] base);
        return overflow ? STATUS_OVERFLOW : base;
    endfunction

    task automatic add_result(input logic [7:0] b, input logic v, input logic d,
                              input logic [1:0] st);
        out_item_t r;
        r.out_byte     = v ? b : 8'h00;
        r.byte_valid   = v;
        r.token_done   = d;
        r.token_status = d ? st : STATUS_OK;
        r.last_flag    = 1'b0;
        step_res[step_cnt] = r;
        step_cnt++;
    endtask

    task automatic end_token();
        mode     = SKIP_WS;
        quoted   = 1'b0;
        depth    = 0;
        overflow = 1'b0;
    endtask

    task automatic open_group(input logic q);
        mode     = IN_GROUP;
        quoted   = q;
        depth    = 1;
        overflow = 1'b0;
    endtask

    task automatic advance_tokenizer(input in_item_t item);
        logic [7:0] b;
        logic       eos;
        logic [7:0] oc;
        logic [7:0] cc;
        int         i;
        b   = item.in_byte;
        eos = item.end_of_stream;
        oc  = quoted ? quote_chr : open_chr;
        cc  = quoted ? quote_chr : close_chr;
        step_cnt = 0;
        case (mode)
            SKIP_WS: begin
                if (eos) begin
                    add_result(8'h00, 1'b0, 1'b1, STATUS_EMPTY);
                    end_token();
                end
                else if (is_space(b)) begin
                end
                else if (b == escape_chr) mode = LEAD_ESC;
                else if (b == quote_chr) open_group(1'b1);
                else if (b == open_chr) open_group(1'b0);
                else begin
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                    mode = IN_WORD;
                end
            end
            LEAD_ESC: begin
                if (eos) begin
                    add_result(escape_chr, 1'b1, 1'b1, STATUS_OK);
                    end_token();
                end
                else begin
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                    mode = LEAD_AFTER;
                end
            end
            LEAD_AFTER: begin
                if (eos || is_space(b)) begin
                    add_result(8'h00, 1'b0, 1'b1, STATUS_OK);
                    end_token();
                end
                else if (b == quote_chr) open_group(1'b1);
                else if (b == open_chr) open_group(1'b0);
                else begin
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                    mode = IN_WORD;
                end
            end
            IN_WORD: begin
                if (eos || is_space(b)) begin
                    add_result(8'h00, 1'b0, 1'b1, STATUS_OK);
                    end_token();
                end
                else if (b == escape_chr) mode = WORD_ESC;
                else add_result(b, 1'b1, 1'b0, STATUS_OK);
            end
            WORD_ESC: begin
                if (eos) begin
                    add_result(escape_chr, 1'b1, 1'b1, STATUS_OK);
                    end_token();
                end
                else begin
                    if (!is_space(b)) add_result(escape_chr, 1'b1, 1'b0, STATUS_OK);
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                    mode = IN_WORD;
                end
            end
            IN_GROUP: begin
                if (eos) begin
                    add_result(8'h00, 1'b0, 1'b1, group_status(STATUS_UNTERM));
                    end_token();
                end
                else if (b == cc) begin
                    if (depth <= 1) begin
                        add_result(8'h00, 1'b0, 1'b1, group_status(STATUS_OK));
                        end_token();
                    end
                    else begin
                        depth--;
                        add_result(b, 1'b1, 1'b0, STATUS_OK);
                    end
                end
                else if (b == oc) begin
                    if (depth >= MAX_DEPTH) overflow = 1'b1;
                    else depth++;
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                end
                else if (b == escape_chr) mode = GROUP_ESC;
                else add_result(b, 1'b1, 1'b0, STATUS_OK);
            end
            GROUP_ESC: begin
                if (eos) begin
                    add_result(escape_chr, 1'b1, 1'b1, group_status(STATUS_UNTERM));
                    end_token();
                end
                else begin
                    if (b != oc && b != cc) add_result(escape_chr, 1'b1, 1'b0, STATUS_OK);
                    add_result(b, 1'b1, 1'b0, STATUS_OK);
                    mode = IN_GROUP;
                end
            end
            default: end_token();
        endcase
        if (step_cnt > 0) step_res[step_cnt - 1].last_flag = 1'b1;
        for (i = 0; i < step_cnt; i++) token_results.push_back(step_res[i]);
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (token_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transaction: byte=%02h valid=%b done=%b status=%0d last=%b",
                         got.out_byte, got.byte_valid, got.token_done, got.token_status,
                         got.last_flag);
        end
        else begin
            want = token_results.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.token_done !== want.token_done || got.token_status !== want.token_status ||
                got.last_flag !== want.last_flag) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %02h %b %b %0d %b, got %02h %b %b %0d %b",
                             want.out_byte, want.byte_valid, want.token_done,
                             want.token_status, want.last_flag, got.out_byte,
                             got.byte_valid, got.token_done, got.token_status, got.last_flag);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_chr    = OPEN_GROUP_RESET;
            close_chr   = CLOSE_GROUP_RESET;
            quote_chr   = QUOTE_RESET;
            escape_chr  = ESCAPE_RESET;
            end_token();
            token_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_OPEN_GROUP:  open_chr   = cfg_data;
                    REG_CLOSE_GROUP: close_chr  = cfg_data;
                    REG_QUOTE:       quote_chr  = cfg_data;
                    REG_ESCAPE:      escape_chr = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) check_result(out_data);
            if (in_valid && in_ready) advance_tokenizer(in_data);
            outstanding = token_results.size();
        end
    end

endmodule

// ===== bench/tb_escaped_brace_quote_tokenizer.sv =====
`timescale 1ns / 100ps
// Testbench top for the escaped brace/quote tokenizer: drives directed and random byte streams
// under several delimiter settings and gives the verdict.
// Depends on ebqt_pkg, ebqt_checker and the escaped_brace_quote_tokenizer RTL.

module tb_escaped_brace_quote_tokenizer;
    import ebqt_pkg::*;

    localparam int MAX_DEPTH     = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = REG_OPEN_GROUP;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    in_item_t   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    out_item_t  out_data;
    int         mismatches;
    int         outstanding;

    bit         throttle   = 1'b1;
    int         items_sent = 0;
    logic [7:0] open_chr   = OPEN_GROUP_RESET;
    logic [7:0] close_chr  = CLOSE_GROUP_RESET;
    logic [7:0] quote_chr  = QUOTE_RESET;
    logic [7:0] escape_chr = ESCAPE_RESET;

    escaped_brace_quote_tokenizer #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ebqt_checker #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= !throttle || ($urandom_range(0, 99) >= 28);
    end

    function automatic logic [7:0] space_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 9) < 7) return 8'("a" + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // One input transaction; valid stays up until the block takes it.
    task automatic send_item(input logic [7:0] b, input logic eos);
        while (throttle && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, end_of_stream: eos};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_eos();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_word();
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(escape_chr, 1'b0);
                send_item($urandom_range(0, 1) ? space_byte() : body_byte(), 1'b0);
            end
            else send_item(body_byte(), 1'b0);
        end
        if ($urandom_range(0, 6) == 0) send_eos();
        else send_item(space_byte(), 1'b0);
    endtask

    task automatic send_quoted();
        send_item(quote_chr, 1'b0);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(escape_chr, 1'b0);
                send_item($urandom_range(0, 1) ? quote_chr : body_byte(), 1'b0);
            end
            else send_item(body_byte(), 1'b0);
        end
        if ($urandom_range(0, 7) == 0) send_eos();
        else send_item(quote_chr, 1'b0);
    endtask

    task automatic send_group(input bit deep);
        int level;
        int r;
        level = 1;
        send_item(open_chr, 1'b0);
        if (deep)
        begin
            repeat ($urandom_range(13, 19))
            begin
                send_item(open_chr, 1'b0);
                level++;
            end
        end
        repeat ($urandom_range(0, 10))
        begin
            case ($urandom_range(0, 5))
                0: begin
                    send_item(open_chr, 1'b0);
                    level++;
                end
                1: begin
                    if (level > 1)
                    begin
                        send_item(close_chr, 1'b0);
                        level--;
                    end
                end
                2: begin
                    send_item(escape_chr, 1'b0);
                    case ($urandom_range(0, 3))
                        0: send_item(open_chr, 1'b0);
                        1: send_item(close_chr, 1'b0);
                        2: send_item(escape_chr, 1'b0);
                        default: send_item(body_byte(), 1'b0);
                    endcase
                end
                default: send_item(body_byte(), 1'b0);
            endcase
        end
        r = $urandom_range(0, 19);
        if (r == 0) send_eos();
        else if (r == 1)
        begin
            send_item(escape_chr, 1'b0);
            send_eos();
        end
        else repeat (level) send_item(close_chr, 1'b0);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) != 0) send_item(space_byte(), 1'b0);
            case ($urandom_range(0, 9))
                0, 1, 2: send_word();
                3, 4: send_quoted();
                5, 6: send_group($urandom_range(0, 6) == 0);
                7: begin
                    send_item(escape_chr, 1'b0);
                    case ($urandom_range(0, 5))
                        0: send_item(space_byte(), 1'b0);
                        1: send_eos();
                        2: send_quoted();
                        3: send_group(1'b0);
                        4: begin
                            send_item(escape_chr, 1'b0);
                            send_word();
                        end
                        default: send_word();
                    endcase
                end
                8: begin
                    repeat ($urandom_range(1, 8))
                    begin
                        if ($urandom_range(0, 9) == 0) send_eos();
                        else send_item(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                default: send_eos();
            endcase
        end
    endtask

    // Waits until every predicted result transaction has come back, then lets the
    // pipeline run dry, since a token may still be in flight without pending results.
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_OPEN_GROUP:  open_chr   = val;
            REG_CLOSE_GROUP: close_chr  = val;
            REG_QUOTE:       quote_chr  = val;
            REG_ESCAPE:      escape_chr = val;
            default: ;
        endcase
    endtask

    task automatic set_chars(input logic [7:0] o, input logic [7:0] c,
                             input logic [7:0] q, input logic [7:0] e);
        drain();
        write_reg(REG_OPEN_GROUP, o);
        write_reg(REG_CLOSE_GROUP, c);
        write_reg(REG_QUOTE, q);
        write_reg(REG_ESCAPE, e);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("escaped_brace_quote_tokenizer: mismatch");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text(" \ta\\ b ");
        send_text("\\");
        send_eos();
        send_eos();
        send_text("{x\\}{}}");
        send_text("\"q");
        send_eos();
        send_text("\\x\"y\"");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h20, 1'b0);
        run_random(300);

        set_chars(8'h00, 8'hFF, 8'h27, 8'h2F);
        run_random(300);

        throttle = 1'b0;
        set_chars(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random(250);

        throttle = 1'b1;
        set_chars(8'h00, 8'h00, 8'h00, 8'h00);
        run_random(250);

        set_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(350);

        set_chars(OPEN_GROUP_RESET, CLOSE_GROUP_RESET, QUOTE_RESET, ESCAPE_RESET);
        run_random(400);

        drain();
        @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("escaped_brace_quote_tokenizer: match");
        else
            $display("escaped_brace_quote_tokenizer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/ebqt_pkg.sv
design/ebqt_core.sv
design/ebqt_outq.sv
design/escaped_brace_quote_tokenizer.sv
design/ebqt_checker.sv
bench/ebqt_checker.sv
bench/tb_escaped_brace_quote_tokenizer.sv
